// File: rtl/core/plrf_pkg.sv
package plrf_pkg;

	localparam int unsigned COORD_W = 24;
	localparam int unsigned INTEN_W = 16;
	localparam int unsigned TIME_W = 63;
	localparam int unsigned INTERVAL_W = 32;
	localparam int unsigned RANGE_W = 48;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE_SQ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_SQ = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTENSITY = 2'd3;

	localparam logic [INTERVAL_W-1:0] RST_SPACING = 32'd10000;
	localparam logic [RANGE_W-1:0] RST_MIN_RANGE_SQ = 48'd0;
	localparam logic [RANGE_W-1:0] RST_MAX_RANGE_SQ = 48'd211106232532992;
	localparam logic [INTEN_W-1:0] RST_MIN_INTENSITY = 16'd0;

	typedef struct packed {
		logic start_of_message;
		logic [TIME_W-1:0] message_stamp;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
		logic [INTEN_W-1:0] intensity;
		logic end_of_message;
	} point_t;

	typedef struct packed {
		logic [TIME_W-1:0] point_time;
		logic later;
		logic advanced;
	} time_res_t;

endpackage

// File: rtl/core/plrf_timestamp.sv
module plrf_timestamp (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic start_of_message,
	input logic [plrf_pkg::TIME_W-1:0] message_stamp,
	input logic end_of_message,
	input logic [plrf_pkg::INTERVAL_W-1:0] spacing,
	output plrf_pkg::time_res_t res
);

	logic [plrf_pkg::TIME_W-1:0] running_time_q;
	logic [plrf_pkg::TIME_W-1:0] head_time_q;
	logic [plrf_pkg::TIME_W:0] sum;
	logic [plrf_pkg::TIME_W-1:0] t;

	// running time never exceeds the top value, so a carry out means saturate
	assign sum = {1'b0, running_time_q} + {{(plrf_pkg::TIME_W + 1 - plrf_pkg::INTERVAL_W){1'b0}},
		spacing};

	always_comb begin
		if (start_of_message) begin
			t = message_stamp;
		end else if (sum[plrf_pkg::TIME_W]) begin
			t = plrf_pkg::TIME_MAX;
		end else begin
			t = sum[plrf_pkg::TIME_W-1:0];
		end
		res.point_time = t;
		res.later = t > head_time_q;
		res.advanced = end_of_message && (t > head_time_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_time_q <= '0;
			head_time_q <= '0;
		end else if (step) begin
			running_time_q <= t;
			if (res.advanced) begin
				head_time_q <= t;
			end
		end
	end

endmodule

// File: rtl/core/plrf_range.sv
module plrf_range (
	input logic signed [plrf_pkg::COORD_W-1:0] x_coord,
	input logic signed [plrf_pkg::COORD_W-1:0] y_coord,
	input logic signed [plrf_pkg::COORD_W-1:0] z_coord,
	input logic [plrf_pkg::RANGE_W-1:0] min_range_squared,
	input logic [plrf_pkg::RANGE_W-1:0] max_range_squared,
	output logic in_range
);

	logic [plrf_pkg::COORD_W-1:0] ax;
	logic [plrf_pkg::COORD_W-1:0] ay;
	logic [plrf_pkg::COORD_W-1:0] az;
	logic [plrf_pkg::RANGE_W-1:0] sx;
	logic [plrf_pkg::RANGE_W-1:0] sy;
	logic [plrf_pkg::RANGE_W-1:0] sz;
	logic [plrf_pkg::RANGE_W-1:0] d2;

	// magnitude of the most negative value still fits as unsigned
	assign ax = x_coord[plrf_pkg::COORD_W-1] ? (~x_coord + 1'b1) : x_coord;
	assign ay = y_coord[plrf_pkg::COORD_W-1] ? (~y_coord + 1'b1) : y_coord;
	assign az = z_coord[plrf_pkg::COORD_W-1] ? (~z_coord + 1'b1) : z_coord;

	assign sx = plrf_pkg::RANGE_W'(ax) * plrf_pkg::RANGE_W'(ax);
	assign sy = plrf_pkg::RANGE_W'(ay) * plrf_pkg::RANGE_W'(ay);
	assign sz = plrf_pkg::RANGE_W'(az) * plrf_pkg::RANGE_W'(az);

	// three squares of at most 2^46 each cannot overflow 48 bits
	assign d2 = sx + sy + sz;
	assign in_range = (d2 >= min_range_squared) && (d2 <= max_range_squared);

endmodule

// File: rtl/core/lidar_point_range_filter.sv
// Lidar point filter: one point per request, one result per point, in order.
// A point is taken every cycle while the result side does not stall; its result
// is held first in the input register and then in the result register, from
// which it is offered. The cycle is set by the 63-bit time add with saturation
// and the head-time compare, alongside three 24-bit squarings and the range
// compares. Writes to the configuration registers belong to idle periods.
module lidar_point_range_filter (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [plrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [plrf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic start_of_message,
	input logic [plrf_pkg::TIME_W-1:0] message_stamp,
	input logic signed [plrf_pkg::COORD_W-1:0] x_coord,
	input logic signed [plrf_pkg::COORD_W-1:0] y_coord,
	input logic signed [plrf_pkg::COORD_W-1:0] z_coord,
	input logic [plrf_pkg::INTEN_W-1:0] intensity,
	input logic end_of_message,
	output logic out_valid,
	input logic out_stall,
	output logic accepted,
	output logic [plrf_pkg::TIME_W-1:0] point_time,
	output logic signed [plrf_pkg::COORD_W-1:0] out_x,
	output logic signed [plrf_pkg::COORD_W-1:0] out_y,
	output logic signed [plrf_pkg::COORD_W-1:0] out_z,
	output logic [plrf_pkg::INTEN_W-1:0] out_intensity,
	output logic message_done,
	output logic head_advanced
);

	logic [plrf_pkg::INTERVAL_W-1:0] spacing_q;
	logic [plrf_pkg::RANGE_W-1:0] min_range_sq_q;
	logic [plrf_pkg::RANGE_W-1:0] max_range_sq_q;
	logic [plrf_pkg::INTEN_W-1:0] min_intensity_q;

	logic valid_s1;
	plrf_pkg::point_t point_s1;
	logic valid_s2;
	logic advance;
	logic step;
	logic in_range;
	logic ok;
	plrf_pkg::time_res_t tres;

	logic accepted_s2;
	logic [plrf_pkg::TIME_W-1:0] time_s2;
	logic signed [plrf_pkg::COORD_W-1:0] x_s2;
	logic signed [plrf_pkg::COORD_W-1:0] y_s2;
	logic signed [plrf_pkg::COORD_W-1:0] z_s2;
	logic [plrf_pkg::INTEN_W-1:0] inten_s2;
	logic done_s2;
	logic adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= plrf_pkg::RST_SPACING;
			min_range_sq_q <= plrf_pkg::RST_MIN_RANGE_SQ;
			max_range_sq_q <= plrf_pkg::RST_MAX_RANGE_SQ;
			min_intensity_q <= plrf_pkg::RST_MIN_INTENSITY;
		end else if (cfg_write) begin
			case (cfg_index)
				plrf_pkg::REG_SPACING: begin
					spacing_q <= cfg_data[plrf_pkg::INTERVAL_W-1:0];
				end
				plrf_pkg::REG_MIN_RANGE_SQ: begin
					min_range_sq_q <= cfg_data[plrf_pkg::RANGE_W-1:0];
				end
				plrf_pkg::REG_MAX_RANGE_SQ: begin
					max_range_sq_q <= cfg_data[plrf_pkg::RANGE_W-1:0];
				end
				plrf_pkg::REG_MIN_INTENSITY: begin
					min_intensity_q <= cfg_data[plrf_pkg::INTEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// the result register frees up when empty or when its result is taken
	assign advance = !valid_s2 || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			point_s1.start_of_message <= start_of_message;
			point_s1.message_stamp <= message_stamp;
			point_s1.x_coord <= x_coord;
			point_s1.y_coord <= y_coord;
			point_s1.z_coord <= z_coord;
			point_s1.intensity <= intensity;
			point_s1.end_of_message <= end_of_message;
		end
	end

	plrf_timestamp u_timestamp (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.start_of_message(point_s1.start_of_message),
		.message_stamp(point_s1.message_stamp),
		.end_of_message(point_s1.end_of_message),
		.spacing(spacing_q),
		.res(tres)
	);

	plrf_range u_range (
		.x_coord(point_s1.x_coord),
		.y_coord(point_s1.y_coord),
		.z_coord(point_s1.z_coord),
		.min_range_squared(min_range_sq_q),
		.max_range_squared(max_range_sq_q),
		.in_range(in_range)
	);

	assign ok = (point_s1.x_coord != '0) && (point_s1.intensity >= min_intensity_q)
		&& tres.later && in_range;

	always_ff @(posedge clk) begin
		if (step) begin
			accepted_s2 <= ok;
			time_s2 <= tres.point_time;
			x_s2 <= point_s1.x_coord;
			y_s2 <= point_s1.y_coord;
			z_s2 <= point_s1.z_coord;
			inten_s2 <= point_s1.intensity;
			done_s2 <= point_s1.end_of_message;
			adv_s2 <= tres.advanced;
		end
	end

	assign out_valid = valid_s2;
	assign accepted = accepted_s2;
	assign point_time = time_s2;
	assign out_x = x_s2;
	assign out_y = y_s2;
	assign out_z = z_s2;
	assign out_intensity = inten_s2;
	assign message_done = done_s2;
	assign head_advanced = adv_s2;

endmodule

// File: rtl/core/plrf_checker.sv
module plrf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic accepted,
	input logic [plrf_pkg::TIME_W-1:0] point_time,
	input logic signed [plrf_pkg::COORD_W-1:0] out_x,
	input logic message_done,
	input logic head_advanced
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_time) && $stable(out_x))
		else $error("stalled result changed");

	// head can only advance on a message end
	a_adv_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && head_advanced |-> message_done)
		else $error("head advanced outside message end");

	// a kept point has nonzero x
	a_acc_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> out_x != '0)
		else $error("point with zero x accepted");

	// a kept point is later than the head, so its time cannot be zero
	a_acc_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (accepted || head_advanced) |-> point_time != '0)
		else $error("zero time kept or advanced head");

endmodule

bind lidar_point_range_filter plrf_checker u_plrf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.accepted(accepted),
	.point_time(point_time),
	.out_x(out_x),
	.message_done(message_done),
	.head_advanced(head_advanced)
);
